// ===== rtl/core/ba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator package
// Shared constants, codes and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package ba_pkg;

  localparam int DEF_MAX_BLOCKS = 256;
  localparam int DEF_ADDR_BITS  = 16;

  localparam int ORD_W  = 5;
  localparam int SIZE_W = 17;
  localparam int OUT_W  = 16;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_ALLOC_ERR = 2'd1;
  localparam logic [STAT_W-1:0] ST_FREE_ERR  = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic REG_HEAP_ORDER = 1'b0;
  localparam logic REG_MIN_ORDER  = 1'b1;

  // Largest l with 2^l <= n.
  function automatic int flog2(input int n);
    int l;
    l = 0;
    while ((2 << l) <= n && l < 30) l++;
    return l;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init;      // start a table clearing pass
    logic load;      // capture the request
    logic scan;      // read next entry of the scan
    logic split;     // perform one split step
    logic free_chk;  // read the entry being freed
    logic free_mark; // clear its used flag
    logic merge_rd;  // read the buddy
    logic merge_do;  // perform one merge
  } ba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic init_done;
    logic bad_req;
    logic scan_done;
    logic found;
    logic split_done;
    logic free_bad;
    logic merge_top;
    logic merge_ok;
  } ba_stat_t;

endpackage

// ===== rtl/core/ba_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one transaction per handshake with a generic payload.
// ----------------------------------------------------------------------------
interface ba_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/ba_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator controller
// Sequences table clearing, scans, splits, frees and merges.
// ----------------------------------------------------------------------------
module ba_ctrl
  import ba_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_hit,
  input  logic     in_valid,
  input  logic     in_func,
  output logic     in_ready,
  output logic     res_load,
  input  logic     res_busy,
  output ba_cmd_t  cmd,
  input  ba_stat_t stat
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_SPLIT  = 4'd4;
  localparam logic [3:0] S_FREE   = 4'd5;
  localparam logic [3:0] S_MRD    = 4'd6;
  localparam logic [3:0] S_MEVAL  = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;
  localparam logic [3:0] S_FWAIT  = 4'd9;

  logic [3:0] state, state_next;
  logic       is_free, is_free_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      is_free <= 1'b0;
    end else begin
      state   <= state_next;
      is_free <= is_free_next;
    end
  end

  always_comb begin
    cmd          = '0;
    state_next   = state;
    is_free_next = is_free;
    in_ready     = 1'b0;
    res_load     = 1'b0;
    unique case (state)
      S_CLEAR: begin
        if (stat.init_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load     = 1'b1;
          is_free_next = in_func;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (is_free) begin
          cmd.free_chk = 1'b1;
          state_next   = S_FWAIT;
        end else if (stat.bad_req) begin
          state_next = S_DONE;
        end else begin
          cmd.scan   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) state_next = stat.found ? S_SPLIT : S_DONE;
        else cmd.scan = 1'b1;
      end
      S_SPLIT: begin
        cmd.split = 1'b1;
        if (stat.split_done) state_next = S_DONE;
      end
      S_FWAIT: begin
        state_next = S_FREE;
      end
      S_FREE: begin
        if (stat.free_bad) begin
          state_next = S_DONE;
        end else begin
          cmd.free_mark = 1'b1;
          state_next    = S_MRD;
        end
      end
      S_MRD: begin
        if (stat.merge_top) begin
          state_next = S_DONE;
        end else begin
          cmd.merge_rd = 1'b1;
          state_next   = S_MEVAL;
        end
      end
      S_MEVAL: begin
        if (stat.merge_ok) begin
          cmd.merge_do = 1'b1;
          state_next   = S_MRD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!res_busy) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
    if (cfg_hit) begin
      cmd.init   = 1'b1;
      state_next = S_CLEAR;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_split_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SPLIT && $past(state) != S_SPLIT) |-> $past(state) == S_SCAN)
    else $error("split entered without scan");
  a_load_once: assert property (@(posedge clk) disable iff (rst)
    res_load |=> !res_load) else $error("double result");

endmodule

// ===== rtl/core/ba_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator datapath
// Granule table memory, configuration, scan, split and merge arithmetic.
// ----------------------------------------------------------------------------
module ba_dp
  import ba_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_idx,
  input  logic [ORD_W-1:0]  cfg_data,
  input  ba_cmd_t           cmd,
  output ba_stat_t          stat,
  input  logic              req_func,
  input  logic [SIZE_W-1:0] req_size,
  input  logic [OUT_W-1:0]  free_addr,
  output logic [STAT_W-1:0] res_status,
  output logic [OUT_W-1:0]  res_addr
);

  localparam int LG  = flog2(MAX_BLOCKS);
  localparam int CNT = 1 << LG;
  localparam int IW  = (LG > 0) ? LG : 1;
  localparam logic [ORD_W-1:0] AB = ORD_W'(ADDR_BITS > 31 ? 31 : ADDR_BITS);

  // Entry: head, used, order.
  localparam int EW = 2 + ORD_W;
  logic [EW-1:0] mem [CNT];
  logic [EW-1:0] rdata;
  logic [IW-1:0] raddr;
  logic          rd_en;
  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rdata <= mem[raddr];
  end

  logic [ORD_W-1:0] heap_order, min_order;
  logic [ORD_W-1:0] h, gs, m;
  logic [IW:0]      clr_cnt;
  logic             clearing;

  assign h  = (heap_order > AB) ? AB : heap_order;
  assign gs = (h > ORD_W'(LG)) ? h - ORD_W'(LG) : '0;
  assign m  = (min_order > gs) ? min_order : gs;

  logic [IW:0] count;
  assign count = (IW+1)'(1) << (h - gs);

  // Request registers.
  logic [ORD_W-1:0] need;
  logic             bad;
  logic [IW:0]      ptr;
  logic [IW-1:0]    bi;
  logic [ORD_W-1:0] best;
  logic             found;
  logic             pend;
  logic             fchk;
  logic [ORD_W-1:0] o;
  logic [IW-1:0]    idx;
  logic [IW-1:0]    bud;
  logic             fbad;
  logic [STAT_W-1:0] st;

  // ceil log2 of size, one compare per order, parallel over orders.
  logic [ORD_W-1:0] need_c;
  always_comb begin
    need_c = '0;
    for (int k = SIZE_W - 1; k >= 0; k--)
      if ((SIZE_W'(1) << k) >= req_size) need_c = ORD_W'(k);
    if (req_size > (SIZE_W'(1) << (SIZE_W - 1))) need_c = ORD_W'(SIZE_W);
  end

  logic [ORD_W-1:0] need_m;
  assign need_m = (need_c < m) ? m : need_c;

  logic [31:0] heap_bytes;
  assign heap_bytes = 32'(1) << h;

  // Per-entry fields of the read data.
  logic             r_head, r_used;
  logic [ORD_W-1:0] r_ord;
  assign {r_head, r_used, r_ord} = rdata;

  logic [ORD_W-1:0] o_dec;
  assign o_dec = o - 1'b1;
  logic [IW-1:0] split_b;
  assign split_b = bi + IW'((IW+1)'(1) << (o_dec - gs));
  logic [IW:0] bud_c;
  assign bud_c = {1'b0, idx} ^ ((IW+1)'(1) << (o - gs));

  logic [OUT_W-1:0] mask;
  assign mask = OUT_W'((32'(1) << gs) - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_order <= ORD_W'(16);
      min_order  <= ORD_W'(8);
      clearing   <= 1'b1;
      clr_cnt    <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_HEAP_ORDER) heap_order <= cfg_data;
        else min_order <= cfg_data;
      end
      if (cmd.init) begin
        clearing <= 1'b1;
        clr_cnt  <= '0;
      end else if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == (IW+1)'(CNT - 1)) clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend <= cmd.scan && (ptr < count);
    fchk <= cmd.free_chk;
    if (cmd.load) begin
      need  <= need_m;
      bad   <= (req_func == FUNC_ALLOC) &&
               ((req_size == '0) || (32'(req_size) > heap_bytes) || (need_m > h));
      ptr   <= '0;
      best  <= '1;
      found <= 1'b0;
      st    <= ST_OK;
      res_addr <= '0;
      idx   <= IW'(free_addr >> gs);
      fbad  <= ((free_addr & mask) != '0) ||
               ((free_addr >> gs) >= OUT_W'(count));
    end
    if (cmd.scan) begin
      ptr  <= ptr + 1'b1;
    end
    if (pend && r_head && !r_used && r_ord >= need && r_ord < best) begin
      best  <= r_ord;
      bi    <= ptr[IW-1:0] - 1'b1;
      found <= 1'b1;
      o     <= r_ord;
    end
    if (cmd.scan && bad) st <= ST_ALLOC_ERR;
    if (!cmd.load && stat.scan_done && !(found || (pend && r_head && !r_used &&
        r_ord >= need && r_ord < best))) st <= ST_ALLOC_ERR;
    if (cmd.split) begin
      if (o > need) o <= o_dec;
      else res_addr <= OUT_W'(32'(bi) << gs);
    end
    if (cmd.free_chk) o <= '0;
    if (cmd.free_mark) o <= r_ord;
    // The entry being freed is valid in the cycle after its read.
    if (fchk && stat.free_bad) st <= ST_FREE_ERR;
    if (cmd.merge_rd) bud <= bud_c[IW-1:0];
    if (cmd.merge_do) begin
      o   <= o + 1'b1;
      idx <= (idx < bud) ? idx : bud;
    end
  end

  // Result status for bad requests comes straight from the bad flag captured at load.
  assign res_status = (bad && !found) ? ST_ALLOC_ERR : st;

  always_comb begin
    stat            = '0;
    stat.init_done  = !clearing;
    stat.bad_req    = bad;
    stat.scan_done  = (ptr >= count) && !pend;
    stat.found      = found;
    stat.split_done = (o <= need);
    stat.free_bad   = fbad || !r_head || !r_used;
    stat.merge_top  = (o >= h) || (({1'b0, idx} ^ ((IW+1)'(1) << (o - gs))) >= count);
    stat.merge_ok   = r_head && !r_used && (r_ord == o);
  end

  // Order of the merged block, written in the cycle after the merge.
  logic          pend_low;
  logic [IW-1:0] low_idx;
  logic [ORD_W-1:0] low_ord;

  always_comb begin
    rd_en = cmd.scan || cmd.free_chk || cmd.merge_rd;
    raddr = cmd.merge_rd ? bud_c[IW-1:0] : (cmd.free_chk ? idx : ptr[IW-1:0]);
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (clearing) begin
      we    = 1'b1;
      waddr = clr_cnt[IW-1:0];
      wdata = (clr_cnt == '0) ? {1'b1, 1'b0, h} : '0;
    end else if (cmd.split) begin
      we = 1'b1;
      if (o > need) begin
        waddr = split_b;
        wdata = {1'b1, 1'b0, o_dec};
      end else begin
        waddr = bi;
        wdata = {1'b1, 1'b1, o};
      end
    end else if (cmd.free_mark) begin
      we    = 1'b1;
      waddr = idx;
      wdata = {1'b1, 1'b0, r_ord};
    end else if (cmd.merge_do) begin
      we    = 1'b1;
      waddr = (idx < bud) ? bud : idx;
      wdata = '0;
    end else if (pend_low) begin
      we    = 1'b1;
      waddr = low_idx;
      wdata = {1'b1, 1'b0, low_ord};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) pend_low <= 1'b0;
    else pend_low <= cmd.merge_do;
    low_idx <= (idx < bud) ? idx : bud;
    low_ord <= o + 1'b1;
  end

  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    pend_low |-> !cmd.merge_do) else $error("merge write clash");
  a_clear_len: assert property (@(posedge clk) disable iff (rst)
    cmd.init |=> clearing) else $error("clear not started");
  a_split_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.split |-> o >= need) else $error("split below need");

endmodule

// ===== rtl/core/buddy_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator unit
// Allocates and frees power-of-two blocks of a heap, one request at a time.
// ----------------------------------------------------------------------------
// The unit handles one transaction at a time. After reset, and after every
// configuration write to heap_order or min_order, the granule table is
// cleared entry by entry, and no request is taken until it is done. An
// allocate scans every granule entry of the heap, one entry per cycle
// through the table memory port, then splits the best block one level per
// step; a free checks and marks the entry, then merges one level per buddy
// read. The result sits in an output register, so the next request may
// start while the previous result is still waiting to be taken.
module buddy_allocator_unit
  import ba_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [ORD_W-1:0] cfg_data,
  ba_stream_if.sink        req,
  ba_stream_if.source      rsp
);

  // The request payload is {func, req_size, free_addr}; the response
  // payload is {status, block_addr}.
  ba_cmd_t  cmd;
  ba_stat_t stat;
  logic     res_load;
  logic     cfg_hit;
  logic [STAT_W-1:0] res_status;
  logic [OUT_W-1:0]  res_addr;

  logic              func;
  logic [SIZE_W-1:0] size_r;
  logic [OUT_W-1:0]  addr_r;
  assign {func, size_r, addr_r} = req.data;

  // Both register indexes exist, so every write reinitializes the table.
  assign cfg_hit = cfg_we;

  ba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_hit  (cfg_hit),
    .in_valid (req.valid),
    .in_func  (func),
    .in_ready (req.ready),
    .res_load (res_load),
    .res_busy (rsp.valid && !rsp.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  ba_dp #(.MAX_BLOCKS(MAX_BLOCKS), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_index[0]),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .req_func   (func),
    .req_size   (size_r),
    .free_addr  (addr_r),
    .res_status (res_status),
    .res_addr   (res_addr)
  );

  // Output register: holds the result until the sink takes it.
  logic out_valid;
  logic [STAT_W+OUT_W-1:0] out_data;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (res_load) out_data <= {res_status, res_addr};
  end
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> $stable(rsp.data)) else $error("result lost");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready) else $error("second request taken");
  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !req.ready) else $error("request during clear");

endmodule
